@@ hdl/roas_pkg.sv @@
`timescale 1ns / 1ps
package roas_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W = 5;

  localparam logic [1:0] FUNC_POSE = 2'd0;
  localparam logic [1:0] FUNC_HIT  = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  localparam logic [2:0] MODE_GOAL    = 3'd0;
  localparam logic [2:0] MODE_AVOID   = 3'd1;
  localparam logic [2:0] MODE_HOLD    = 3'd2;
  localparam logic [2:0] MODE_TRANS   = 3'd3;
  localparam logic [2:0] MODE_ARRIVED = 3'd4;

  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_GOAL_TOL  = 3'd2;
  localparam logic [2:0] REG_OBST_THR  = 3'd3;
  localparam logic [2:0] REG_NARROW    = 3'd4;
  localparam logic [2:0] REG_CRUISE    = 3'd5;
  localparam logic [2:0] REG_STEER_LIM = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_AVOID, ST_SQRT1, ST_DIV, ST_SQRT2, ST_ATAN, ST_MUL, ST_OUT
  } roas_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input item accepted
    logic start_mag; // load dx/dy
    logic start_avd; // init narrow*256 / max(range,256)
    logic start_sq1; // init sqrt of dx^2+dy^2
    logic start_div; // init 2^40 / d
    logic start_sq2; // init sqrt of quotient
    logic start_at;  // init cordic
    logic step;      // iterate active unit
    logic do_mul;    // theta * g
    logic load_out;  // capture result
  } roas_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic near;
    logic arrived;
    logic avoid_path; // avoid or hold: no goal math
    logic unit_done;
  } roas_sts_t;

  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0: v = 16'd51472;  4'd1: v = 16'd30385;
      4'd2: v = 16'd16055;  4'd3: v = 16'd8150;
      4'd4: v = 16'd4091;   4'd5: v = 16'd2047;
      4'd6: v = 16'd1024;   4'd7: v = 16'd512;
      4'd8: v = 16'd256;    4'd9: v = 16'd128;
      4'd10: v = 16'd64;    4'd11: v = 16'd32;
      4'd12: v = 16'd16;    4'd13: v = 16'd8;
      4'd14: v = 16'd4;     default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/reactive_obstacle_avoid_steer.sv @@
`timescale 1ns / 1ps
// Steering controller, one command per scan. Pose and hit items can follow back
// to back while no end item is pending. An end item runs through a shared
// restoring sqrt/divide unit (18 steps for the distance, 41 for 2^40/d, 17 for
// the gain) and a 16-step cordic for the goal bearing before a drive or
// transition result is offered. Arrived and hold results are loaded from the
// magnitude state without the unit; avoid runs a 23-step divide on the same
// unit. One item is handled at a time: the input stalls from an end item until
// its result is taken.
module reactive_obstacle_avoid_steer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic signed [15:0] in_robot_heading,
  input  logic [15:0]        in_beam_range,
  input  logic signed [15:0] in_beam_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_speed_cmd,
  output logic signed [15:0] out_steer_cmd,
  output logic [2:0]         out_mode,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import roas_pkg::*;

  roas_cmd_t cmd;
  roas_sts_t sts;

  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0] tol_r, narrow_r, lim_r;
  logic [15:0] thr_r, cruise_r;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= 16'sd5120; goal_y_r <= '0; tol_r <= 15'd192;
      thr_r <= 16'd1024; narrow_r <= 15'd2144; cruise_r <= 16'd2560;
      lim_r <= 15'd3573;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_GOAL_X:    goal_x_r <= pwdata[15:0];
        REG_GOAL_Y:    goal_y_r <= pwdata[15:0];
        REG_GOAL_TOL:  tol_r    <= pwdata[14:0];
        REG_OBST_THR:  thr_r    <= pwdata[15:0];
        REG_NARROW:    narrow_r <= pwdata[14:0];
        REG_CRUISE:    cruise_r <= pwdata[15:0];
        REG_STEER_LIM: lim_r    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_GOAL_X:    prdata = 32'(unsigned'(goal_x_r));
      REG_GOAL_Y:    prdata = 32'(unsigned'(goal_y_r));
      REG_GOAL_TOL:  prdata = 32'(tol_r);
      REG_OBST_THR:  prdata = 32'(thr_r);
      REG_NARROW:    prdata = 32'(narrow_r);
      REG_CRUISE:    prdata = 32'(cruise_r);
      REG_STEER_LIM: prdata = 32'(lim_r);
      default:       prdata = '0;
    endcase
  end

  roas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  roas_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_func(in_func),
    .in_robot_x(in_robot_x), .in_robot_y(in_robot_y),
    .in_robot_heading(in_robot_heading), .in_beam_range(in_beam_range),
    .in_beam_angle(in_beam_angle), .goal_x(goal_x_r), .goal_y(goal_y_r),
    .goal_tol(tol_r), .obst_thr(thr_r), .narrow(narrow_r), .cruise(cruise_r),
    .steer_lim(lim_r), .out_speed_cmd(out_speed_cmd),
    .out_steer_cmd(out_steer_cmd), .out_mode(out_mode)
  );

endmodule

@@ hdl/roas_ctrl.sv @@
`timescale 1ns / 1ps
module roas_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  output logic               out_valid,
  input  logic               out_stall,
  input  roas_pkg::roas_sts_t sts,
  output roas_pkg::roas_cmd_t cmd
);
  import roas_pkg::*;

  roas_state_t state_r, state_nxt;
  logic        acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc && in_func == FUNC_END) state_nxt = ST_MAG;
      ST_MAG: begin
        priority if (sts.arrived) state_nxt = ST_OUT;
        else if (sts.near) state_nxt = ST_AVOID;
        else if (sts.avoid_path) state_nxt = ST_OUT;
        else state_nxt = ST_SQRT1;
      end
      ST_AVOID: if (sts.unit_done) state_nxt = ST_OUT;
      ST_SQRT1: if (sts.unit_done) state_nxt = ST_DIV;
      ST_DIV:   if (sts.unit_done) state_nxt = ST_SQRT2;
      ST_SQRT2: if (sts.unit_done) state_nxt = ST_ATAN;
      ST_ATAN:  if (sts.unit_done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.take = acc;
    unique case (state_r)
      ST_IDLE: cmd.start_mag = acc && in_func == FUNC_END;
      ST_MAG: begin
        priority if (sts.arrived) cmd.load_out = 1'b1;
        else if (sts.near) cmd.start_avd = 1'b1;
        else if (sts.avoid_path) cmd.load_out = 1'b1;
        else cmd.start_sq1 = 1'b1;
      end
      ST_AVOID: begin
        cmd.step     = 1'b1;
        cmd.load_out = sts.unit_done;
      end
      ST_SQRT1: begin
        cmd.step      = 1'b1;
        cmd.start_div = sts.unit_done;
      end
      ST_DIV: begin
        cmd.step      = 1'b1;
        cmd.start_sq2 = sts.unit_done;
      end
      ST_SQRT2: begin
        cmd.step     = 1'b1;
        cmd.start_at = sts.unit_done;
      end
      ST_ATAN: cmd.step = 1'b1;
      ST_MUL: begin
        cmd.do_mul   = 1'b1;
        cmd.load_out = 1'b1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ hdl/roas_dp.sv @@
`timescale 1ns / 1ps
module roas_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  roas_pkg::roas_cmd_t cmd,
  output roas_pkg::roas_sts_t sts,
  input  logic [1:0]          in_func,
  input  logic signed [15:0]  in_robot_x,
  input  logic signed [15:0]  in_robot_y,
  input  logic signed [15:0]  in_robot_heading,
  input  logic [15:0]         in_beam_range,
  input  logic signed [15:0]  in_beam_angle,
  input  logic signed [15:0]  goal_x,
  input  logic signed [15:0]  goal_y,
  input  logic [14:0]         goal_tol,
  input  logic [15:0]         obst_thr,
  input  logic [14:0]         narrow,
  input  logic [15:0]         cruise,
  input  logic [14:0]         steer_lim,
  output logic [15:0]         out_speed_cmd,
  output logic signed [15:0]  out_steer_cmd,
  output logic [2:0]          out_mode
);
  import roas_pkg::*;

  logic signed [15:0] pose_x_r, pose_y_r, pose_h_r;
  logic               near_r, side_r, wide_r;
  logic [15:0]        near_range_r;

  // hit classification
  logic [15:0] abs_a;
  logic [19:0] a10, n17, n22;
  assign abs_a = in_beam_angle[15] ? 16'(-in_beam_angle) : in_beam_angle;
  assign a10   = 20'(abs_a) * 20'd10;
  assign n17   = 20'(narrow) * 20'd17;
  assign n22   = 20'(narrow) * 20'd22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0; pose_y_r <= '0; pose_h_r <= '0;
      near_r <= 1'b0; side_r <= 1'b0; wide_r <= 1'b0;
      near_range_r <= 16'd256;
    end else if (cmd.take) begin
      if (in_func == FUNC_POSE) begin
        pose_x_r <= in_robot_x; pose_y_r <= in_robot_y; pose_h_r <= in_robot_heading;
        near_r <= 1'b0; side_r <= 1'b0; wide_r <= 1'b0;
        near_range_r <= 16'd256;
      end else if (in_func == FUNC_HIT && in_beam_range < obst_thr) begin
        if (abs_a < 16'(narrow)) begin
          near_r <= 1'b1;
          near_range_r <= in_beam_range;
        end else if (a10 < n17) side_r <= 1'b1;
        else if (a10 < n22) wide_r <= 1'b1;
      end
    end
  end

  // goal geometry
  logic signed [16:0] dx_r, dy_r;
  logic [16:0]        adx, ady;
  logic signed [16:0] dxc, dyc;
  assign dxc = 17'(goal_x) - 17'(pose_x_r);
  assign dyc = 17'(goal_y) - 17'(pose_y_r);
  assign adx = dx_r[16] ? 17'(-dx_r) : dx_r;
  assign ady = dy_r[16] ? 17'(-dy_r) : dy_r;
  assign sts.arrived    = (adx < 17'(goal_tol)) && (ady < 17'(goal_tol));
  assign sts.avoid_path = near_r || side_r;
  assign sts.near       = near_r;

  // shared restoring unit: sqrt (bit pair per step) or divide (bit per step)
  logic [41:0] rem_r;     // remainder / radicand work
  logic [41:0] src_r;     // remaining radicand bits or dividend
  logic [33:0] root_r;    // sqrt root or quotient
  logic [5:0]  cnt_r;
  logic        is_div_r;
  logic [16:0] den_r;
  logic [16:0] g_r;

  logic [35:0] sq_sum;
  assign sq_sum = 36'(adx) * 36'(adx) + 36'(ady) * 36'(ady);

  logic [43:0] trial_s, rem_s;
  logic [42:0] trial_d, rem_d;
  logic [35:0] tsub;
  always_comb begin
    rem_s   = {rem_r, src_r[41:40]};
    tsub    = {root_r, 2'b01};
    trial_s = rem_s - 44'(tsub);
    rem_d   = {rem_r, src_r[41]};
    trial_d = rem_d - 43'(den_r);
  end

  assign sts.unit_done = (cnt_r == '0) && !cmd.start_sq1;

  // cordic
  logic signed [35:0] cx_r, cy_r;
  logic signed [21:0] cz_r;
  logic [3:0]         ci_r;
  logic signed [35:0] xs, ys;
  logic signed [16:0] fx, fy;
  logic signed [21:0] fz;
  assign xs = cx_r >>> ci_r;
  assign ys = cy_r >>> ci_r;
  always_comb begin
    fx = dx_r; fy = dy_r; fz = '0;
    if (dx_r[16]) begin
      if (!dy_r[16]) begin fx = dy_r; fy = 17'(-dx_r); fz = 22'sd102944; end
      else begin fx = 17'(-dy_r); fy = dx_r; fz = -22'sd102944; end
    end
  end

  logic        at_active_r;
  logic        steer_pos;
  logic [22:0] amag_num;
  logic [16:0] rclip;
  logic [16:0] avoid_q;
  logic [25:0] yten;

  assign yten = 26'(signed'(pose_y_r)) * 26'sd10;
  assign steer_pos = $signed(yten) < -26'sd256;

  // avoid magnitude: narrow*256 / max(range,256) on the shared divider
  always_comb amag_num = {narrow, 8'd0};
  assign rclip   = (near_range_r < 16'd256) ? 17'd256 : 17'(near_range_r);
  assign avoid_q = root_r[16:0];

  always_ff @(posedge clk) begin
    if (cmd.start_mag) begin
      dx_r <= dxc;
      dy_r <= dyc;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      at_active_r <= 1'b0;
    end else if (cmd.start_sq1) begin
      rem_r <= '0; src_r <= {sq_sum, 6'd0}; root_r <= '0;
      cnt_r <= 6'd18; is_div_r <= 1'b0;
    end else if (cmd.start_avd) begin
      den_r <= rclip;
      rem_r <= '0; src_r <= {amag_num, 19'd0}; root_r <= '0;
      cnt_r <= 6'd23; is_div_r <= 1'b1;
    end else if (cmd.start_div) begin
      den_r <= (root_r[16:0] < 17'd256) ? 17'd256 : root_r[16:0];
      rem_r <= '0; src_r <= {1'b1, 41'd0}; root_r <= '0;
      cnt_r <= 6'd41; is_div_r <= 1'b1;
    end else if (cmd.start_sq2) begin
      rem_r <= '0; src_r <= {root_r, 8'd0}; root_r <= '0;
      cnt_r <= 6'd17; is_div_r <= 1'b0;
    end else if (cmd.start_at) begin
      g_r <= root_r[16:0];
      if (dx_r == 0 && dy_r == 0) begin
        cx_r <= '0; cy_r <= '0; cz_r <= '0; at_active_r <= 1'b0; cnt_r <= 6'd0;
      end else begin
        cx_r <= 36'(fx) <<< 14; cy_r <= 36'(fy) <<< 14; cz_r <= fz;
        ci_r <= '0; cnt_r <= 6'd16; at_active_r <= 1'b1;
      end
    end else if (cmd.step && cnt_r != 0) begin
      cnt_r <= cnt_r - 6'd1;
      if (at_active_r) begin
        if (!cy_r[35]) begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 22'(atan_entry(ci_r));
        end else begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 22'(atan_entry(ci_r));
        end
        ci_r <= ci_r + 4'd1;
        if (cnt_r == 6'd1) at_active_r <= 1'b0;
      end else if (is_div_r) begin
        src_r <= src_r << 1;
        if (!trial_d[42]) begin
          rem_r <= trial_d[41:0]; root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r <= rem_d[41:0]; root_r <= {root_r[32:0], 1'b0};
        end
      end else begin
        src_r <= src_r << 2;
        if (!trial_s[43]) begin
          rem_r <= trial_s[41:0]; root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r <= rem_s[41:0]; root_r <= {root_r[32:0], 1'b0};
        end
      end
    end
  end

  // final product and result
  logic signed [21:0] az;
  logic signed [21:0] theta;
  logic signed [39:0] prod;
  logic signed [39:0] pq;
  logic signed [21:0] st;
  logic signed [21:0] lim;
  assign az    = (cz_r + 22'sd8) >>> 4;
  assign theta = az - 22'(pose_h_r);
  assign prod  = 40'(theta) * $signed({23'd0, g_r});
  always_comb begin
    if (wide_r) pq = (prod + (prod[39] ? 40'sd131071 : 40'sd0)) >>> 17;
    else        pq = (prod + (prod[39] ? 40'sd65535 : 40'sd0)) >>> 16;
  end
  assign lim = 22'(steer_lim);

  // speed scaling by 4/5 and 9/10 through reciprocal multiplication
  logic [17:0] c4v, c4, c9;
  logic [19:0] c9v;
  logic [38:0] c4p;
  logic [44:0] c9p;
  assign c4v = {cruise, 2'b00};
  assign c4p = 39'(c4v) * 39'd419431;
  assign c4  = c4p[38:21];
  assign c9v = 20'(cruise) * 20'd9;
  assign c9p = 45'(c9v) * 45'd1677722;
  assign c9  = c9p[41:24];

  always_comb begin
    st = '0;
    if (sts.arrived) st = '0;
    else if (near_r) st = steer_pos ? 22'(avoid_q) : -22'(avoid_q);
    else if (side_r) st = '0;
    else st = -22'(pq);
    if (st > lim) st = lim;
    if (st < -lim) st = -lim;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_steer_cmd <= st[15:0];
      if (sts.arrived) begin
        out_speed_cmd <= '0; out_mode <= MODE_ARRIVED;
      end else if (near_r) begin
        out_speed_cmd <= c4[15:0]; out_mode <= MODE_AVOID;
      end else if (side_r) begin
        out_speed_cmd <= c4[15:0]; out_mode <= MODE_HOLD;
      end else if (wide_r) begin
        out_speed_cmd <= c9[15:0]; out_mode <= MODE_TRANS;
      end else begin
        out_speed_cmd <= cruise; out_mode <= MODE_GOAL;
      end
    end
  end

endmodule

@@ verif/reactive_obstacle_avoid_steer_tb.sv @@
`timescale 1ns / 1ps
module reactive_obstacle_avoid_steer_tb;
  import roas_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [15:0] speed;
    logic [15:0] steer;
    logic [2:0]  mode;
  } steer_cmd_t;

  localparam longint ATAN_STEP [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_func;
  logic signed [15:0] in_robot_x, in_robot_y, in_robot_heading, in_beam_angle;
  logic [15:0] in_beam_range;
  logic out_valid, out_stall;
  logic [15:0] out_speed_cmd;
  logic signed [15:0] out_steer_cmd;
  logic [2:0] out_mode;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  // predictor copy of registers and scan state
  longint goal_x, goal_y, goal_tol, obst_thr, narrow_ang, cruise, steer_lim;
  longint pos_x, pos_y, pos_hdg, near_dist;
  bit flag_near, flag_side, flag_wide;

  steer_cmd_t cmd_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit calm = 0;

  reactive_obstacle_avoid_steer dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint bearing_q12(longint yy, longint xx);
    longint z, t, xs, ys;
    z = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      t = xx;
      if (yy >= 0) begin
        xx = yy; yy = -t; z = 102944;
      end else begin
        xx = -yy; yy = t; z = -102944;
      end
    end
    xx = xx * 16384;
    yy = yy * 16384;
    for (int i = 0; i < 16; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (yy >= 0) begin
        xx += ys; yy -= xs; z += ATAN_STEP[i];
      end else begin
        xx -= ys; yy += xs; z -= ATAN_STEP[i];
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_item(logic [1:0] f, logic [15:0] x, logic [15:0] y,
                              logic [15:0] h, logic [15:0] rng, logic [15:0] ang);
    longint dx, dy, st, a, d, g, p;
    steer_cmd_t c;
    if (f == FUNC_POSE) begin
      pos_x = sx16(x); pos_y = sx16(y); pos_hdg = sx16(h);
      flag_near = 0; flag_side = 0; flag_wide = 0; near_dist = 256;
    end else if (f == FUNC_HIT) begin
      a = abs_l(sx16(ang));
      if (longint'(rng) < obst_thr) begin
        if (a < narrow_ang) begin
          flag_near = 1; near_dist = rng;
        end else if (a * 10 < narrow_ang * 17) flag_side = 1;
        else if (a * 10 < narrow_ang * 22) flag_wide = 1;
      end
    end else if (f == FUNC_END) begin
      dx = goal_x - pos_x;
      dy = goal_y - pos_y;
      st = 0;
      if (abs_l(dx) < goal_tol && abs_l(dy) < goal_tol) begin
        c.speed = 0; c.mode = MODE_ARRIVED;
      end else if (flag_near) begin
        d = near_dist < 256 ? 256 : near_dist;
        st = (narrow_ang * 256) / d;
        if (!(pos_y * 10 < -256)) st = -st;
        c.speed = 16'((cruise * 4) / 5); c.mode = MODE_AVOID;
      end else if (flag_side) begin
        c.speed = 16'((cruise * 4) / 5); c.mode = MODE_HOLD;
      end else begin
        d = int_sqrt(dx * dx + dy * dy);
        if (d < 256) d = 256;
        g = int_sqrt((64'd1 << 40) / d);
        p = (bearing_q12(dy, dx) - pos_hdg) * g;
        if (flag_wide) begin
          c.speed = 16'((cruise * 9) / 10); st = -(p / 131072); c.mode = MODE_TRANS;
        end else begin
          c.speed = 16'(cruise); st = -(p / 65536); c.mode = MODE_GOAL;
        end
      end
      if (st > steer_lim) st = steer_lim;
      if (st < -steer_lim) st = -steer_lim;
      c.steer = 16'(st);
      cmd_q.push_back(c);
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] f, logic [15:0] x, logic [15:0] y,
                           logic [15:0] h, logic [15:0] rng, logic [15:0] ang);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_func = f; in_robot_x = x; in_robot_y = y; in_robot_heading = h;
    in_beam_range = rng; in_beam_angle = ang;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    predict_item(f, x, y, h, rng, ang);
    @(negedge clk);
  endtask

  task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [15:0] h);
    send_item(FUNC_POSE, x, y, h, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_hit(logic [15:0] rng, logic [15:0] ang);
    send_item(FUNC_HIT, 16'($urandom), 16'($urandom), 16'($urandom), rng, ang);
  endtask

  task automatic send_end();
    send_item(FUNC_END, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // block idle: no item offered, all commands back, pipeline drained
  task automatic drain();
    in_valid = 0;
    wait (cmd_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = 32'(val);
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    case (idx)
      REG_GOAL_X:    goal_x = sx16(val[15:0]);
      REG_GOAL_Y:    goal_y = sx16(val[15:0]);
      REG_GOAL_TOL:  goal_tol = val & 'h7fff;
      REG_OBST_THR:  obst_thr = val & 'hffff;
      REG_NARROW:    narrow_ang = val & 'h7fff;
      REG_CRUISE:    cruise = val & 'hffff;
      REG_STEER_LIM: steer_lim = val & 'h7fff;
      default: ;
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic write_all(longint gx, longint gy, longint tol, longint thr,
                           longint nar, longint spd, longint lim);
    drain();
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_GOAL_TOL, tol);
    write_reg(REG_OBST_THR, thr);
    write_reg(REG_NARROW, nar);
    write_reg(REG_CRUISE, spd);
    write_reg(REG_STEER_LIM, lim);
  endtask

  // one scan with random hits, mostly aimed around the sectors
  task automatic random_scan();
    logic [15:0] x, y, h, rng, ang;
    int n;
    longint span;
    if ($urandom_range(0, 4) == 0) begin
      x = 16'(goal_x + $urandom_range(0, 2 * goal_tol + 64) - goal_tol - 32);
      y = 16'(goal_y + $urandom_range(0, 2 * goal_tol + 64) - goal_tol - 32);
    end else begin
      x = 16'($urandom); y = 16'($urandom);
      if ($urandom_range(0, 1)) begin
        x = 16'(goal_x + $urandom_range(0, 4096) - 2048);
        y = 16'($urandom_range(0, 1024) - 512);
      end
    end
    h = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
    send_pose(x, y, h);
    n = $urandom_range(0, 6);
    span = narrow_ang * 3 > 32767 ? 32767 : narrow_ang * 3;
    repeat (n) begin
      rng = ($urandom_range(0, 9) < 6 && obst_thr > 0) ? 16'($urandom_range(0, obst_thr - 1))
                                                      : 16'($urandom);
      ang = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
      send_hit(rng, ang);
    end
    send_end();
    if ($urandom_range(0, 9) == 0) send_end();
  endtask

  task automatic test_directed();
    send_pose(0, 0, 0);
    send_end();                                  // drive toward goal
    send_hit(0, 0);
    send_end();                                  // avoid, negative turn
    send_pose(16'h0000, -16'sd256, 16'sd100);
    send_hit(16'd512, -16'sd10);
    send_hit(16'd700, 16'sd5);                   // last narrow range kept
    send_end();                                  // avoid, positive turn
    send_pose(16'd100, 16'd50, 16'hffff);
    send_hit(16'd10, 16'd2144);                  // on narrow edge -> medium
    send_end();
    send_pose(16'd100, 16'd50, 16'h1000);
    send_hit(16'd10, 16'd3645);                  // just past medium edge -> wide
    send_hit(16'd1024, 16'd0);                   // range at threshold ignored
    send_end();
    send_item(FUNC_SPARE, 16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0);
    send_end();
    send_pose(16'd5120, 16'd0, 16'd0);
    send_end();                                  // arrived
    send_pose(16'h8000, 16'h7fff, 16'h8000);
    send_hit(16'hffff, 16'h8000);
    send_hit(16'd0, 16'h7fff);
    send_end();
    send_pose(16'h7fff, 16'h8000, 16'h7fff);
    send_end();
  endtask

  task automatic test_config_sweep();
    write_all(-32768, 32767, 0, 65535, 32767, 65535, 32767);
    repeat (4) random_scan();
    write_all(32767, -32768, 32767, 0, 0, 0, 0);
    repeat (4) random_scan();
    write_all(0, 0, 1, 300, 1, 1, 1);
    repeat (4) random_scan();
    write_all(-2000, 1500, 100, 2048, 4000, 40000, 8000);
    repeat (6) random_scan();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    calm = 1;
    repeat (6) begin
      send_end();
      send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    end
    calm = 0;
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 200 == 199)
        write_all(16'($urandom), 16'($urandom), $urandom_range(0, 2000),
                  $urandom_range(0, 65535), $urandom_range(0, 8000),
                  $urandom_range(0, 65535), $urandom_range(0, 32767));
      calm = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 9) < 8) begin
        random_scan();
        sent += 6;
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(FUNC_SPARE, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
          1: begin send_hit(16'($urandom), 16'($urandom)); sent++; end
          default: begin send_end(); sent++; end
        endcase
      end
    end
    calm = 0;
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall = 1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall = 1;
      stall_left = pick_gap();
    end else begin
      out_stall = 0;
    end
  end

  always @(posedge clk) begin
    steer_cmd_t c;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_q.size() == 0) begin
        $error("command with no item pending: speed %0d steer %0d mode %0d",
               out_speed_cmd, out_steer_cmd, out_mode);
        errors++;
      end else begin
        c = cmd_q.pop_front();
        if (out_speed_cmd !== c.speed) begin
          $error("speed_cmd expected %0d got %0d", c.speed, out_speed_cmd);
          errors++;
        end
        if (out_steer_cmd !== c.steer) begin
          $error("steer_cmd expected %0d got %0d", signed'(c.steer), out_steer_cmd);
          errors++;
        end
        if (out_mode !== c.mode) begin
          $error("mode expected %0d got %0d", c.mode, out_mode);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_func = FUNC_POSE; in_robot_x = 0; in_robot_y = 0;
    in_robot_heading = 0; in_beam_range = 0; in_beam_angle = 0;
    out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    goal_x = 5120; goal_y = 0; goal_tol = 192; obst_thr = 1024;
    narrow_ang = 2144; cruise = 2560; steer_lim = 3573;
    pos_x = 0; pos_y = 0; pos_hdg = 0; near_dist = 256;
    flag_near = 0; flag_side = 0; flag_wide = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    write_all(5120, 0, 192, 1024, 2144, 2560, 3573);
    test_random();
    drain();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/roas_pkg.sv
hdl/roas_ctrl.sv
hdl/roas_dp.sv
hdl/reactive_obstacle_avoid_steer.sv
verif/reactive_obstacle_avoid_steer_tb.sv
